// ----- rtl/mtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mtu_pkg
// Shared types, constants and helpers for the matrix transform unit.
// ----------------------------------------------------------------------------
package mtu_pkg;

	localparam int DATA_W         = 32;  // operand and result width
	localparam int FRAC_BITS      = 16;  // Q16.16
	localparam int DIM            = 4;   // matrix is DIM x DIM
	localparam int COEF_WIDTH_DEF = 32;
	localparam int ONE_Q16        = 65536;

	typedef enum logic [2:0] {
		OP_LOAD_COL   = 3'd0,
		OP_LOAD_DIAG  = 3'd1,
		OP_TRANSLATE  = 3'd2,
		OP_SCALE      = 3'd3,
		OP_TRANSFORM  = 3'd4
	} op_t;

	// control of the word held in the product stage
	typedef struct packed {
		logic       valid;
		op_t        op;
		logic [1:0] col;
	} stage_ctrl_t;

	// what the merge stage decides for that word
	typedef struct packed {
		logic mat_we;
		logic res_valid;
	} merge_ctrl_t;

	// ops that rewrite the matrix
	function automatic logic is_writer(input op_t op);
		logic w;
		unique case (op)
			OP_LOAD_COL, OP_LOAD_DIAG, OP_TRANSLATE, OP_SCALE: w = 1'b1;
			default:                                           w = 1'b0;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/mtu_row_lane.sv -----
// ----------------------------------------------------------------------------
// mtu_row_lane
// One matrix row: four Q16.16 products of the row coefficients with the
// operand vector, floor-shifted by 16 and registered.
// ----------------------------------------------------------------------------
module mtu_row_lane
	import mtu_pkg::*;
#(
	parameter int CW = COEF_WIDTH_DEF,
	parameter int PW = CW + DATA_W - FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [CW-1:0]     coef [DIM],
	input  logic signed [DATA_W-1:0] vec  [DIM],
	output logic signed [PW-1:0]     prod [DIM]
);

	logic signed [CW+DATA_W-1:0] full [DIM];

	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			full[c] = (CW + DATA_W)'(coef[c]) * (CW + DATA_W)'(vec[c]);
		end
	end

	// dropping the low fraction bits of a two's complement product floors it
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < DIM; c++) begin
				prod[c] <= full[c][CW+DATA_W-1:FRAC_BITS];
			end
		end
	end

endmodule

// ----- rtl/mtu_merge.sv -----
// ----------------------------------------------------------------------------
// mtu_merge
// Combines the lane products: row sums with saturation for transform and
// translate, per-entry saturation for scale, and the load operations.
// ----------------------------------------------------------------------------
module mtu_merge
	import mtu_pkg::*;
#(
	parameter int CW = COEF_WIDTH_DEF,
	parameter int PW = CW + DATA_W - FRAC_BITS
) (
	input  stage_ctrl_t              ctrl,
	input  logic signed [DATA_W-1:0] vec   [DIM],
	input  logic signed [PW-1:0]     prod  [DIM][DIM],  // [row][col]
	input  logic signed [CW-1:0]     mat   [DIM][DIM],  // [col][row]
	output merge_ctrl_t              upd,
	output logic signed [CW-1:0]     mat_d [DIM][DIM],
	output logic signed [CW-1:0]     res   [DIM]
);

	localparam int SUM_W = PW + 2;

	localparam logic signed [SUM_W-1:0]  SUM_MAX = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SUM_W-1:0]  SUM_MIN = {{(SUM_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] IN_MAX  = {{(DATA_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] IN_MIN  = {{(DATA_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

	function automatic logic signed [CW-1:0] sat_sum(input logic signed [SUM_W-1:0] a);
		logic signed [CW-1:0] r;
		if (a > SUM_MAX)      r = SUM_MAX[CW-1:0];
		else if (a < SUM_MIN) r = SUM_MIN[CW-1:0];
		else                  r = a[CW-1:0];
		return r;
	endfunction

	function automatic logic signed [CW-1:0] sat_in(input logic signed [DATA_W-1:0] a);
		logic signed [CW-1:0] r;
		if (a > IN_MAX)      r = IN_MAX[CW-1:0];
		else if (a < IN_MIN) r = IN_MIN[CW-1:0];
		else                 r = a[CW-1:0];
		return r;
	endfunction

	logic signed [SUM_W-1:0] sum_tf [DIM];
	logic signed [SUM_W-1:0] sum_tr [DIM];

	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			sum_tf[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1])
			          + SUM_W'(prod[r][2]) + SUM_W'(prod[r][3]);
			sum_tr[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1])
			          + SUM_W'(prod[r][2]) + SUM_W'(mat[3][r]);
			res[r]    = sat_sum(sum_tf[r]);
		end
	end

	always_comb begin
		mat_d = mat;
		unique case (ctrl.op)
			OP_LOAD_COL: begin
				for (int r = 0; r < DIM; r++) begin
					mat_d[ctrl.col][r] = sat_in(vec[r]);
				end
			end
			OP_LOAD_DIAG: begin
				for (int c = 0; c < DIM; c++) begin
					for (int r = 0; r < DIM; r++) begin
						mat_d[c][r] = (c == r) ? sat_in(vec[0]) : '0;
					end
				end
			end
			OP_TRANSLATE: begin
				for (int r = 0; r < DIM; r++) begin
					mat_d[3][r] = sat_sum(sum_tr[r]);
				end
			end
			OP_SCALE: begin
				for (int c = 0; c < DIM - 1; c++) begin
					for (int r = 0; r < DIM; r++) begin
						mat_d[c][r] = sat_sum(SUM_W'(prod[r][c]));
					end
				end
			end
			default: ;
		endcase
	end

	assign upd.mat_we    = ctrl.valid && is_writer(ctrl.op);
	assign upd.res_valid = ctrl.valid && (ctrl.op == OP_TRANSFORM);

endmodule

// ----- rtl/matrix_transform_unit.sv -----
// ----------------------------------------------------------------------------
// matrix_transform_unit
// 4x4 Q16.16 matrix with load, scale, translate and vertex transform.
// ----------------------------------------------------------------------------
// Takes one word per cycle while no matrix update or output stall holds it.
// A transform word passes the input, product and output registers before
// its result shows. Four row lanes of four CWx32 multipliers each form all
// sixteen products in the product stage; a word that rewrites the matrix
// (load column, load diagonal, translate, scale) commits it when it leaves
// that stage, so the word behind it waits for that commit before it reads
// the matrix. Ignored op codes and transforms flow without gaps. The result
// sits in an output register, so new words keep entering while a result
// waits to be taken, until a second transform reaches the product stage.
module matrix_transform_unit
	import mtu_pkg::*;
#(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  logic [2:0]               operation,
	input  logic [1:0]               column_index,
	input  logic signed [DATA_W-1:0] x_value,
	input  logic signed [DATA_W-1:0] y_value,
	input  logic signed [DATA_W-1:0] z_value,
	input  logic signed [DATA_W-1:0] w_value,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [DATA_W-1:0] out_x,
	output logic signed [DATA_W-1:0] out_y,
	output logic signed [DATA_W-1:0] out_z,
	output logic signed [DATA_W-1:0] out_w
);

	localparam int CW = (COEF_WIDTH < DATA_W) ? COEF_WIDTH : DATA_W;
	localparam int PW = CW + DATA_W - FRAC_BITS;

	// identity diagonal, saturated for narrow coefficients
	localparam logic signed [CW-1:0] DIAG_RST =
		(CW >= FRAC_BITS + 2) ? CW'(ONE_Q16) : {1'b0, {(CW-1){1'b1}}};

	// matrix, [col][row]
	logic signed [CW-1:0]     mat_q [DIM][DIM];
	logic signed [CW-1:0]     mat_d [DIM][DIM];

	// input stage
	logic                     valid_s1;
	op_t                      op_s1;
	logic [1:0]               col_s1;
	logic signed [DATA_W-1:0] vec_s1 [DIM];

	// product stage
	stage_ctrl_t              ctrl_s2;
	logic signed [DATA_W-1:0] vec_s2 [DIM];
	logic signed [PW-1:0]     prod_s2 [DIM][DIM];

	// output register
	logic                     res_valid_q;
	logic signed [CW-1:0]     res_q [DIM];
	logic signed [CW-1:0]     res_d [DIM];

	merge_ctrl_t              upd;

	logic out_free, s2_leave, s2_free, s1_adv, res_load;

	assign out_free   = !res_valid_q || result_ready;
	assign s2_leave   = ctrl_s2.valid && (ctrl_s2.op != OP_TRANSFORM || out_free);
	assign s2_free    = !ctrl_s2.valid || s2_leave;
	// a writer in the product stage commits this edge; the next word reads after it
	assign s1_adv     = valid_s1 && s2_free && !upd.mat_we;
	assign item_ready = !valid_s1 || s1_adv;
	assign res_load   = upd.res_valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			ctrl_s2     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_ready) valid_s1 <= item_valid;
			if (s1_adv) begin
				ctrl_s2.valid <= 1'b1;
				ctrl_s2.op    <= op_s1;
				ctrl_s2.col   <= col_s1;
			end else if (s2_leave) begin
				ctrl_s2.valid <= 1'b0;
			end
			if (res_load)          res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < DIM; c++) begin
				for (int r = 0; r < DIM; r++) begin
					mat_q[c][r] <= (c == r) ? DIAG_RST : '0;
				end
			end
		end else if (upd.mat_we) begin
			mat_q <= mat_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1     <= op_t'(operation);
			col_s1    <= column_index;
			vec_s1[0] <= x_value;
			vec_s1[1] <= y_value;
			vec_s1[2] <= z_value;
			vec_s1[3] <= w_value;
		end
		if (s1_adv) vec_s2 <= vec_s1;
		if (res_load) res_q <= res_d;
	end

	for (genvar r = 0; r < DIM; r++) begin : g_lane
		logic signed [CW-1:0] coef [DIM];

		always_comb begin
			for (int c = 0; c < DIM; c++) begin
				coef[c] = mat_q[c][r];
			end
		end

		mtu_row_lane #(
			.CW (CW),
			.PW (PW)
		) u_lane (
			.clk  (clk),
			.en   (s1_adv),
			.coef (coef),
			.vec  (vec_s1),
			.prod (prod_s2[r])
		);
	end

	mtu_merge #(
		.CW (CW),
		.PW (PW)
	) u_merge (
		.ctrl  (ctrl_s2),
		.vec   (vec_s2),
		.prod  (prod_s2),
		.mat   (mat_q),
		.upd   (upd),
		.mat_d (mat_d),
		.res   (res_d)
	);

	assign result_valid = res_valid_q;
	assign out_x        = DATA_W'(res_q[0]);
	assign out_y        = DATA_W'(res_q[1]);
	assign out_z        = DATA_W'(res_q[2]);
	assign out_w        = DATA_W'(res_q[3]);

	// a result only appears after a transform left the product stage
	a_res_from_transform: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(ctrl_s2.valid && ctrl_s2.op == OP_TRANSFORM))
		else $error("result without a transform word");

	// a transform blocked by a full output register stays in place
	a_transform_held: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s2.valid && ctrl_s2.op == OP_TRANSFORM && !out_free)
		|=> (ctrl_s2.valid && ctrl_s2.op == OP_TRANSFORM))
		else $error("transform word lost under output stall");

	// the word behind a matrix writer must not read the matrix in the same cycle
	a_writer_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && upd.mat_we) |=> valid_s1)
		else $error("word advanced past a matrix update");

	// matrix entries [3][0] and [0][0] only change when a writer commits
	a_matrix_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!upd.mat_we |=> $stable(mat_q[3][0]) && $stable(mat_q[0][0]))
		else $error("matrix changed without a writer");

endmodule
